// File: rtl/ras_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_pkg
// Shared types, constants and fixed-point helpers of the annulus sampler.
// ----------------------------------------------------------------------------
package ras_pkg;

  localparam int RAS_CORDIC_STAGES = 24;

  // Configuration register indexes.
  localparam logic [2:0] REG_OUTER_RADIUS    = 3'd0;
  localparam logic [2:0] REG_INNER_RADIUS    = 3'd1;
  localparam logic [2:0] REG_TILT_ANGLE      = 3'd2;
  localparam logic [2:0] REG_AZIMUTH_ANGLE   = 3'd3;
  localparam logic [2:0] REG_TARGET_X        = 3'd4;
  localparam logic [2:0] REG_TARGET_Y        = 3'd5;
  localparam logic [2:0] REG_TARGET_Z        = 3'd6;
  localparam logic [2:0] REG_SOURCE_DISTANCE = 3'd7;

  localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;
  localparam logic signed [63:0] Q30_HALF     = 64'sd536870912;
  localparam logic signed [63:0] HALF_PI_Q30  = 64'sd1686629713;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  // Latency of the radius path: four arithmetic stages and one root cell per bit.
  localparam int SQRT_BITS = 24;
  localparam int RADIUS_LAT = 4 + SQRT_BITS;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         q;
  } ras_cordic_t;

  typedef struct packed {
    logic [47:0] rad;
    logic [27:0] rem;
    logic [23:0] root;
  } ras_sqrt_t;

  function automatic logic signed [33:0] ras_atan(input int i);
    logic signed [33:0] a;
    case (i)
      0: a = 34'sd843314856;   1: a = 34'sd497837829;
      2: a = 34'sd263043836;   3: a = 34'sd133525158;
      4: a = 34'sd67021686;    5: a = 34'sd33543515;
      6: a = 34'sd16775850;    7: a = 34'sd8388437;
      8: a = 34'sd4194282;     9: a = 34'sd2097149;
      10: a = 34'sd1048575;    11: a = 34'sd524287;
      12: a = 34'sd262143;     13: a = 34'sd131071;
      14: a = 34'sd65535;      15: a = 34'sd32767;
      16: a = 34'sd16383;      17: a = 34'sd8191;
      18: a = 34'sd4095;       19: a = 34'sd2047;
      20: a = 34'sd1023;       21: a = 34'sd511;
      22: a = 34'sd255;        23: a = 34'sd127;
      24: a = 34'sd63;         25: a = 34'sd31;
      26: a = 34'sd15;         27: a = 34'sd8;
      28: a = 34'sd4;          29: a = 34'sd2;
      30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

  // Q2.30 product, rounded to nearest with ties upward.
  function automatic logic signed [63:0] ras_mulq(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    return (a * b + Q30_HALF) >>> 30;
  endfunction

  function automatic logic signed [31:0] ras_clamp(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd1073741824) r = 32'sd1073741824;
    else if (v < -64'sd1073741824) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/ras_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_delay
// Enabled shift line that lines up two paths of different latency.
// ----------------------------------------------------------------------------
module ras_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);
  generate
    if (D == 0) begin : g_none
      assign d_o = d_i;
    end else begin : g_line
      logic [W-1:0] tap_r [0:D-1];
      always_ff @(posedge clk) begin
        if (en) begin
          tap_r[0] <= d_i;
          for (int k = 1; k < D; k++) tap_r[k] <= tap_r[k-1];
        end
      end
      assign d_o = tap_r[D-1];
    end
  endgenerate
endmodule

// File: rtl/ras_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_sqrt_cell
// One digit of the integer square root; produces one root bit per cycle while en is high.
// ----------------------------------------------------------------------------
module ras_sqrt_cell #(
  parameter int K = 0
) (
  input  logic              clk,
  input  logic              en,
  input  ras_pkg::ras_sqrt_t s_i,
  output ras_pkg::ras_sqrt_t s_o
);
  import ras_pkg::*;

  ras_sqrt_t s_r, s_nxt;
  logic [27:0] acc;
  logic [27:0] trial;

  always_comb begin
    acc   = {s_i.rem[25:0], s_i.rad[47-2*K -: 2]};
    trial = {2'b00, s_i.root, 2'b01};
    s_nxt.rad = s_i.rad;
    if (acc >= trial) begin
      s_nxt.rem  = acc - trial;
      s_nxt.root = {s_i.root[22:0], 1'b1};
    end else begin
      s_nxt.rem  = acc;
      s_nxt.root = {s_i.root[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) s_r <= s_nxt;
  end

  assign s_o = s_r;
endmodule

// File: rtl/ras_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_cordic_cell
// One rotation-mode CORDIC micro-rotation with its shift fixed by I.
// ----------------------------------------------------------------------------
module ras_cordic_cell #(
  parameter int I = 0
) (
  input  logic                clk,
  input  logic                en,
  input  ras_pkg::ras_cordic_t c_i,
  output ras_pkg::ras_cordic_t c_o
);
  import ras_pkg::*;

  ras_cordic_t c_r, c_nxt;

  always_comb begin
    c_nxt.q = c_i.q;
    if (!c_i.z[33]) begin
      c_nxt.x = c_i.x - (c_i.y >>> I);
      c_nxt.y = c_i.y + (c_i.x >>> I);
      c_nxt.z = c_i.z - ras_atan(I);
    end else begin
      c_nxt.x = c_i.x + (c_i.y >>> I);
      c_nxt.y = c_i.y - (c_i.x >>> I);
      c_nxt.z = c_i.z + ras_atan(I);
    end
  end

  always_ff @(posedge clk) begin
    if (en) c_r <= c_nxt;
  end

  assign c_o = c_r;
endmodule

// File: rtl/ras_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_sincos
// Pipelined sine and cosine of a 32-bit phase: quadrant fold, CORDIC chain,
// clamp and unfold.
// ----------------------------------------------------------------------------
module ras_sincos #(
  parameter int STAGES = ras_pkg::RAS_CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import ras_pkg::*;

  ras_cordic_t chain [0:STAGES];
  ras_cordic_t prep_r, prep_nxt;
  logic signed [31:0] cos_r, sin_r, cos_nxt, sin_nxt;
  logic [31:0] qsum, resid;
  logic signed [63:0] zprod;
  logic signed [31:0] cx, cy;

  always_comb begin
    qsum  = phase + 32'h2000_0000;
    resid = phase - {qsum[31:30], 30'd0};
    zprod = ((64'($signed(resid)) * HALF_PI_Q30) + Q30_HALF) >>> 30;
    prep_nxt.x = CORDIC_START;
    prep_nxt.y = 34'sd0;
    prep_nxt.z = zprod[33:0];
    prep_nxt.q = qsum[31:30];
  end

  always_ff @(posedge clk) begin
    if (en) prep_r <= prep_nxt;
  end

  assign chain[0] = prep_r;

  generate
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
      ras_cordic_cell #(.I(g)) u_cell (
        .clk (clk),
        .en  (en),
        .c_i (chain[g]),
        .c_o (chain[g+1])
      );
    end
  endgenerate

  always_comb begin
    cx = ras_clamp(64'(chain[STAGES].x));
    cy = ras_clamp(64'(chain[STAGES].y));
    case (chain[STAGES].q)
      2'd0: begin cos_nxt = cx;  sin_nxt = cy;  end
      2'd1: begin cos_nxt = -cy; sin_nxt = cx;  end
      2'd2: begin cos_nxt = -cx; sin_nxt = -cy; end
      default: begin cos_nxt = cy; sin_nxt = -cx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;
endmodule

// File: rtl/rotated_annulus_source_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_annulus_source_sampler
// Draws a start point uniformly over a tilted, rotated annulus and returns
// the start position and unit beam direction.
// ----------------------------------------------------------------------------
// The sampler takes one transfer per clock cycle while in_stall is low and
// returns one result per transfer, in order. The radius path is four
// arithmetic stages (input register included) followed by a chain of 24
// square-root cells (one root bit per cell), the three sine/cosine units are
// the input register, a quadrant stage, a chain of CORDIC_STAGES rotation
// cells and a clamp stage, and the shorter path is delayed to match the
// longer one before four product and sum stages. The whole pipeline advances
// together; in_stall is raised only while a result waits in the output
// register and out_stall is high. Configuration must be written while no
// transfer is in flight.
module rotated_annulus_source_sampler #(
  parameter int CORDIC_STAGES = ras_pkg::RAS_CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_radius_fraction,
  input  logic [31:0]        in_angle_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_dir_x,
  output logic signed [31:0] out_dir_y,
  output logic signed [31:0] out_dir_z
);
  import ras_pkg::*;

  // Both latencies count from the input transfer, the input register included.
  localparam int ANGLE_LAT = CORDIC_STAGES + 3;
  localparam int ALIGN_LAT = (RADIUS_LAT > ANGLE_LAT) ? RADIUS_LAT : ANGLE_LAT;
  localparam int VLD_LEN   = ALIGN_LAT + 3;

  // Configuration registers.
  logic [23:0]        outer_r, inner_r;
  logic [15:0]        tilt_r, azim_r;
  logic signed [31:0] tgt_x_r, tgt_y_r, tgt_z_r;
  logic [30:0]        dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_r <= '0; inner_r <= '0; tilt_r <= '0; azim_r <= '0;
      tgt_x_r <= '0; tgt_y_r <= '0; tgt_z_r <= '0; dist_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTER_RADIUS:    outer_r <= cfg_data[23:0];
        REG_INNER_RADIUS:    inner_r <= cfg_data[23:0];
        REG_TILT_ANGLE:      tilt_r  <= cfg_data[15:0];
        REG_AZIMUTH_ANGLE:   azim_r  <= cfg_data[15:0];
        REG_TARGET_X:        tgt_x_r <= cfg_data;
        REG_TARGET_Y:        tgt_y_r <= cfg_data;
        REG_TARGET_Z:        tgt_z_r <= cfg_data;
        REG_SOURCE_DISTANCE: dist_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being drained.
  logic en;
  logic out_valid_r;
  logic [VLD_LEN-1:0] vld_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VLD_LEN-2:0], in_valid};
      out_valid_r <= vld_r[VLD_LEN-1];
    end
  end

  // Input register.
  logic [31:0] u_r, v_r;
  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= in_radius_fraction;
      v_r <= in_angle_fraction;
    end
  end

  // Radius path: squared radii, interpolation by the radius fraction.
  logic [47:0] ro2_r, ri2_r, ri2b_r, ri2c_r, d_r, ph_r;
  logic [31:0] u1_r, u2_r, pl_r;
  logic        ge_r, ge2_r;
  logic [63:0] plo;
  logic [47:0] psum, r2;
  ras_sqrt_t   sq [0:SQRT_BITS];

  assign plo  = 64'(d_r[31:0]) * 64'(u2_r);
  assign psum = ph_r + 48'(pl_r);
  assign r2   = ge2_r ? (ri2c_r + psum) : (ri2c_r - psum);

  always_ff @(posedge clk) begin
    if (en) begin
      ro2_r  <= 48'(outer_r) * 48'(outer_r);
      ri2_r  <= 48'(inner_r) * 48'(inner_r);
      u1_r   <= u_r;
      ge_r   <= ro2_r >= ri2_r;
      d_r    <= (ro2_r >= ri2_r) ? (ro2_r - ri2_r) : (ri2_r - ro2_r);
      ri2b_r <= ri2_r;
      u2_r   <= u1_r;
      ph_r   <= 48'(d_r[47:32]) * 48'(u2_r);
      pl_r   <= plo[63:32];
      ge2_r  <= ge_r;
      ri2c_r <= ri2b_r;
    end
  end

  // The fourth stage (r2) feeds the first root cell directly.
  assign sq[0].rad  = r2;
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;

  generate
    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
      ras_sqrt_cell #(.K(k)) u_sqrt (
        .clk (clk),
        .en  (en),
        .s_i (sq[k]),
        .s_o (sq[k+1])
      );
    end
  endgenerate

  // Three sine/cosine units: tilt, azimuth and disk angle.
  logic signed [31:0] ct, st, cp, sp, cd, sd;

  ras_sincos #(.STAGES(CORDIC_STAGES)) u_tilt (
    .clk (clk), .en (en), .phase ({tilt_r, 16'd0}), .cos_o (ct), .sin_o (st)
  );
  ras_sincos #(.STAGES(CORDIC_STAGES)) u_azim (
    .clk (clk), .en (en), .phase ({azim_r, 16'd0}), .cos_o (cp), .sin_o (sp)
  );
  ras_sincos #(.STAGES(CORDIC_STAGES)) u_disk (
    .clk (clk), .en (en), .phase (v_r), .cos_o (cd), .sin_o (sd)
  );

  // Line the two paths up.
  logic [23:0]  r_al;
  logic [191:0] trig_al;

  ras_delay #(.W(24), .D(ALIGN_LAT - RADIUS_LAT)) u_dly_r (
    .clk (clk), .en (en), .d_i (sq[SQRT_BITS].root), .d_o (r_al)
  );
  ras_delay #(.W(192), .D(ALIGN_LAT - ANGLE_LAT)) u_dly_t (
    .clk (clk), .en (en), .d_i ({ct, st, cp, sp, cd, sd}), .d_o (trig_al)
  );

  logic signed [31:0] a_ct, a_st, a_cp, a_sp, a_cd, a_sd;
  assign {a_ct, a_st, a_cp, a_sp, a_cd, a_sd} = trig_al;

  // First product stage: direction and disk-plane point.
  logic signed [31:0] p1_zx_r, p1_zy_r, p1_ct_r, p1_st_r, p1_cp_r, p1_sp_r;
  logic signed [25:0] p1_dx_r, p1_dy_r;
  logic signed [63:0] m_dx, m_dy;

  assign m_dx = ras_mulq(64'(r_al), 64'(a_cd));
  assign m_dy = ras_mulq(64'(r_al), 64'(a_sd));

  always_ff @(posedge clk) begin
    if (en) begin
      p1_zx_r <= ras_clamp(ras_mulq(64'(a_st), 64'(a_cp)));
      p1_zy_r <= ras_clamp(ras_mulq(64'(a_st), 64'(a_sp)));
      p1_dx_r <= m_dx[25:0];
      p1_dy_r <= m_dy[25:0];
      p1_ct_r <= a_ct;
      p1_st_r <= a_st;
      p1_cp_r <= a_cp;
      p1_sp_r <= a_sp;
    end
  end

  // Second product stage: tilt rotation and the backward offsets.
  logic signed [25:0] p2_tx_r, p2_ty_r, p2_tz_r;
  logic signed [32:0] p2_wx_r, p2_wy_r, p2_wz_r;
  logic signed [31:0] p2_zx_r, p2_zy_r, p2_zz_r, p2_cp_r, p2_sp_r;
  logic signed [63:0] m_tx, m_tz, m_wx, m_wy, m_wz;

  assign m_tx = ras_mulq(64'(p1_dx_r), 64'(p1_ct_r));
  assign m_tz = -ras_mulq(64'(p1_dx_r), 64'(p1_st_r));
  assign m_wx = ras_mulq(64'(p1_zx_r), 64'(dist_r));
  assign m_wy = ras_mulq(64'(p1_zy_r), 64'(dist_r));
  assign m_wz = ras_mulq(64'(p1_ct_r), 64'(dist_r));

  always_ff @(posedge clk) begin
    if (en) begin
      p2_tx_r <= m_tx[25:0];
      p2_ty_r <= p1_dy_r;
      p2_tz_r <= m_tz[25:0];
      p2_wx_r <= m_wx[32:0];
      p2_wy_r <= m_wy[32:0];
      p2_wz_r <= m_wz[32:0];
      p2_zx_r <= p1_zx_r;
      p2_zy_r <= p1_zy_r;
      p2_zz_r <= p1_ct_r;
      p2_cp_r <= p1_cp_r;
      p2_sp_r <= p1_sp_r;
    end
  end

  // Third product stage: azimuth rotation.
  logic signed [25:0] p3_a_r, p3_b_r, p3_c_r, p3_e_r, p3_tz_r;
  logic signed [32:0] p3_wx_r, p3_wy_r, p3_wz_r;
  logic signed [31:0] p3_zx_r, p3_zy_r, p3_zz_r;
  logic signed [63:0] m_a, m_b, m_c, m_e;

  assign m_a = ras_mulq(64'(p2_tx_r), 64'(p2_cp_r));
  assign m_b = ras_mulq(64'(p2_ty_r), 64'(p2_sp_r));
  assign m_c = ras_mulq(64'(p2_ty_r), 64'(p2_cp_r));
  assign m_e = ras_mulq(64'(p2_tx_r), 64'(p2_sp_r));

  always_ff @(posedge clk) begin
    if (en) begin
      p3_a_r  <= m_a[25:0];
      p3_b_r  <= m_b[25:0];
      p3_c_r  <= m_c[25:0];
      p3_e_r  <= m_e[25:0];
      p3_tz_r <= p2_tz_r;
      p3_wx_r <= p2_wx_r;
      p3_wy_r <= p2_wy_r;
      p3_wz_r <= p2_wz_r;
      p3_zx_r <= p2_zx_r;
      p3_zy_r <= p2_zy_r;
      p3_zz_r <= p2_zz_r;
    end
  end

  // Final sums, saturation and the output register.
  logic signed [35:0] px, py, pz;
  logic signed [31:0] px_nxt, py_nxt, pz_nxt;
  logic signed [31:0] opx_r, opy_r, opz_r, odx_r, ody_r, odz_r;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -36'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    px = 36'(p3_a_r) - 36'(p3_b_r) + 36'(tgt_x_r) - 36'(p3_wx_r);
    py = 36'(p3_c_r) + 36'(p3_e_r) + 36'(tgt_y_r) - 36'(p3_wy_r);
    pz = 36'(p3_tz_r) + 36'(tgt_z_r) - 36'(p3_wz_r);
    px_nxt = sat32(px);
    py_nxt = sat32(py);
    pz_nxt = sat32(pz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opx_r <= px_nxt;
      opy_r <= py_nxt;
      opz_r <= pz_nxt;
      odx_r <= p3_zx_r;
      ody_r <= p3_zy_r;
      odz_r <= p3_zz_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = opx_r;
  assign out_pos_y = opy_r;
  assign out_pos_z = opz_r;
  assign out_dir_x = odx_r;
  assign out_dir_y = ody_r;
  assign out_dir_z = odz_r;
endmodule
